// ===== design/mm3_pkg.sv =====
// Shared types, constants and helper functions for the MurmurHash3 stream hash unit.
// No dependencies; every other design file imports this package.
package mm3_pkg;

   localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
   localparam logic [31:0] MM_C2 = 32'h1b873593;
   localparam logic [31:0] MM_N  = 32'he6546b64;
   localparam logic [31:0] MM_F1 = 32'h85ebca6b;
   localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 3;
   localparam logic REG_SEED = 1'b0;

   typedef enum logic [1:0] {
      OP_ABSORB     = 2'd0,
      OP_FINISH     = 2'd1,
      OP_ABSORB_FIN = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      BK_IDLE = 3'd0,
      BK_SCR1 = 3'd1,
      BK_SCR2 = 3'd2,
      BK_MIX  = 3'd3,
      BK_AV1  = 3'd4,
      BK_AV2  = 3'd5,
      BK_EMIT = 3'd6
   } bk_state_type;

   typedef struct packed {
      op_type      op;
      logic        start;
      logic [31:0] seed;
      logic [31:0] word;
      logic        has_tail;
      logic [31:0] length;
   } qentry_type;

   function automatic logic [31:0] rotl15(input logic [31:0] x);
      return {x[16:0], x[31:17]};
   endfunction

   function automatic logic [31:0] rotl13(input logic [31:0] x);
      return {x[18:0], x[31:19]};
   endfunction

endpackage

// ===== design/mm3_front.sv =====
// Front end: accepts key bytes, packs words, counts length and emits work beats.
// Depends on mm3_pkg for the queue entry and operation types.
module mm3_front
   import mm3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_carries_byte,
   input  logic        req_last,
   input  logic [31:0] seed,
   input  logic        q_full,
   output logic        q_push,
   output qentry_type  q_entry
);

   logic        in_key_ff, in_key_in;
   logic        start_pend_ff, start_pend_in;
   logic [31:0] key_seed_ff, key_seed_in;
   logic [23:0] partial_ff, partial_in;
   logic [1:0]  phase_ff, phase_in;
   logic [31:0] len_ff, len_in;

   logic        accept, active, start, sp, full_word;
   logic [1:0]  ph, ph_next;
   logic [23:0] pw, pw_pack, pw_next;
   logic [31:0] ln, ln_next, sd;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign active    = accept && (req_carries_byte || req_last);

   always_comb begin
      start     = !in_key_ff;
      ph        = start ? 2'd0 : phase_ff;
      pw        = start ? 24'd0 : partial_ff;
      ln        = start ? 32'd0 : len_ff;
      sp        = start || start_pend_ff;
      sd        = start ? seed : key_seed_ff;
      full_word = req_carries_byte && (ph == 2'd3);
      ln_next   = ln + {31'd0, req_carries_byte};
      ph_next   = req_carries_byte ? ph + 2'd1 : ph;
      case (ph)
         2'd0:    pw_pack = {pw[23:8], req_data_byte};
         2'd1:    pw_pack = {pw[23:16], req_data_byte, pw[7:0]};
         2'd2:    pw_pack = {req_data_byte, pw[15:0]};
         default: pw_pack = pw;
      endcase
      if (!req_carries_byte) begin
         pw_next = pw;
      end else if (full_word) begin
         pw_next = 24'd0;
      end else begin
         pw_next = pw_pack;
      end
   end

   always_comb begin
      q_push           = active && (full_word || req_last);
      q_entry.start    = sp;
      q_entry.seed     = sd;
      q_entry.length   = ln_next;
      q_entry.has_tail = (ph_next != 2'd0);
      q_entry.word     = full_word ? {req_data_byte, pw} : {8'd0, pw_next};
      if (full_word && req_last) begin
         q_entry.op = OP_ABSORB_FIN;
      end else if (full_word) begin
         q_entry.op = OP_ABSORB;
      end else begin
         q_entry.op = OP_FINISH;
      end
   end

   always_comb begin
      in_key_in     = in_key_ff;
      start_pend_in = start_pend_ff;
      key_seed_in   = key_seed_ff;
      partial_in    = partial_ff;
      phase_in      = phase_ff;
      len_in        = len_ff;
      if (active) begin
         if (req_last) begin
            in_key_in     = 1'b0;
            start_pend_in = 1'b0;
            partial_in    = 24'd0;
            phase_in      = 2'd0;
            len_in        = 32'd0;
         end else begin
            in_key_in     = 1'b1;
            start_pend_in = sp && !q_push;
            key_seed_in   = sd;
            partial_in    = pw_next;
            phase_in      = ph_next;
            len_in        = ln_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_key_ff     <= 1'b0;
         start_pend_ff <= 1'b0;
         partial_ff    <= 24'd0;
         phase_ff      <= 2'd0;
         len_ff        <= 32'd0;
      end else begin
         in_key_ff     <= in_key_in;
         start_pend_ff <= start_pend_in;
         partial_ff    <= partial_in;
         phase_ff      <= phase_in;
         len_ff        <= len_in;
      end
      key_seed_ff <= key_seed_in;
   end

endmodule

// ===== design/mm3_queue.sv =====
// Short FIFO of work beats between the front end and the mixing back end.
// Depends on mm3_pkg for the entry type and depth constants.
module mm3_queue
   import mm3_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  qentry_type push_entry,
   output logic       full,
   output logic       not_empty,
   input  logic       pop,
   output qentry_type pop_entry
);

   qentry_type       mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_entry = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== design/mm3_back.sv =====
// Back end: mixes words into the running hash and finalizes keys on one shared multiplier.
// Depends on mm3_pkg for the state, operation and entry types and the hash constants.
module mm3_back
   import mm3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_not_empty,
   input  qentry_type  q_entry,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value
);

   bk_state_type state_ff, state_in;
   op_type       op_ff, op_in;
   logic [31:0]  word_ff, word_in;
   logic         tail_ff, tail_in;
   logic [31:0]  len_ff, len_in;
   logic [31:0]  hash_ff, hash_in;
   logic [31:0]  acc_ff, acc_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [31:0]  rsp_hash_ff, rsp_hash_in;

   logic [31:0]  mul_a, mul_b, mul_prod;
   logic [31:0]  mix_x, av_x;
   logic         out_free;

   assign mul_prod       = mul_a * mul_b;
   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;
   assign mix_x          = rotl13(hash_ff ^ acc_ff);
   assign av_x           = hash_ff ^ len_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_not_empty) begin
               if (q_entry.op != OP_FINISH || q_entry.has_tail) begin
                  state_in = BK_SCR1;
               end else begin
                  state_in = BK_AV1;
               end
            end
         end
         BK_SCR1: state_in = BK_SCR2;
         BK_SCR2: state_in = BK_MIX;
         BK_MIX: begin
            state_in = (op_ff == OP_ABSORB) ? BK_IDLE : BK_AV1;
         end
         BK_AV1:  state_in = BK_AV2;
         BK_AV2:  state_in = BK_EMIT;
         BK_EMIT: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop        = 1'b0;
      op_in        = op_ff;
      word_in      = word_ff;
      tail_in      = tail_ff;
      len_in       = len_ff;
      hash_in      = hash_ff;
      acc_in       = acc_ff;
      mul_a        = acc_ff;
      mul_b        = MM_C2;
      rsp_hash_in  = rsp_hash_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         BK_IDLE: begin
            q_pop = q_not_empty;
            if (q_not_empty) begin
               op_in   = q_entry.op;
               word_in = q_entry.word;
               tail_in = q_entry.has_tail;
               len_in  = q_entry.length;
               if (q_entry.start) begin
                  hash_in = q_entry.seed;
               end
            end
         end
         BK_SCR1: begin
            mul_a  = word_ff;
            mul_b  = MM_C1;
            acc_in = mul_prod;
         end
         BK_SCR2: begin
            mul_a  = rotl15(acc_ff);
            mul_b  = MM_C2;
            acc_in = mul_prod;
         end
         BK_MIX: begin
            if (op_ff == OP_FINISH) begin
               hash_in = hash_ff ^ acc_ff;
            end else begin
               hash_in = mix_x + {mix_x[29:0], 2'b00} + MM_N;
            end
         end
         BK_AV1: begin
            mul_a  = av_x ^ {16'd0, av_x[31:16]};
            mul_b  = MM_F1;
            acc_in = mul_prod;
         end
         BK_AV2: begin
            mul_a  = acc_ff ^ {13'd0, acc_ff[31:13]};
            mul_b  = MM_F2;
            acc_in = mul_prod;
         end
         BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = acc_ff ^ {16'd0, acc_ff[31:16]};
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      word_ff     <= word_in;
      tail_ff     <= tail_in;
      len_ff      <= len_in;
      hash_ff     <= hash_in;
      acc_ff      <= acc_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   a_av2_to_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_AV2 |=> state_ff == BK_EMIT)
      else $error("avalanche did not advance to emit");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == BK_EMIT))
      else $error("result beat raised outside emit");

   a_pop_in_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == BK_IDLE && q_not_empty))
      else $error("queue popped while busy or empty");

   a_absorb_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_MIX && op_ff == OP_ABSORB) |=> state_ff == BK_IDLE)
      else $error("absorb beat did not return to idle");

endmodule

// ===== design/murmur3_32_stream_hash_unit.sv =====
// Top level of the MurmurHash3 x86_32 stream hash unit: seed register and block wiring.
// Depends on mm3_pkg, mm3_front, mm3_queue and mm3_back.
//
//   channel   direction   handshake                     payload
//   req       in          req_valid / req_stall         data_byte, carries_byte, last
//   rsp       out         rsp_valid / rsp_stall         hash_value
//   csr       in          psel/penable/pwrite/pready    seed at byte address 0
//
// The front end takes one byte per cycle while the two-beat queue has room.
// A full word passes the back end's idle, scramble and mix states on its shared
// multiplier, so long keys stream at one byte per cycle while the queue has room;
// finalizing adds the avalanche and emit states and stalls the front once the queue fills.
// Reset is synchronous and clears control state; the seed resets to zero.
// A stalled result is held in the output register while the front keeps accepting.
module murmur3_32_stream_hash_unit
   import mm3_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_carries_byte,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [31:0]           rsp_hash_value,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [31:0] seed_ff, seed_in;
   logic        csr_wr;
   logic        q_full, q_push, q_not_empty, q_pop;
   qentry_type  q_push_entry, q_pop_entry;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_SEED) ? seed_ff : 32'd0;

   always_comb begin
      seed_in = seed_ff;
      if (csr_wr && csr_paddr[CSR_ADDR_W-1] == REG_SEED) begin
         seed_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 32'd0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   mm3_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_carries_byte (req_carries_byte),
      .req_last         (req_last),
      .seed             (seed_ff),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (q_push_entry)
   );

   mm3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .pop        (q_pop),
      .pop_entry  (q_pop_entry)
   );

   mm3_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (q_not_empty),
      .q_entry        (q_pop_entry),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule
